// File: hdl/mrf_pkg.sv
`default_nettype none

package mrf_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned RegAddrW   = 16;
  localparam int unsigned CrcW       = 16;
  localparam int unsigned FrameBytes = 8;
  localparam int unsigned PosW       = $clog2(FrameBytes);

  localparam logic [CrcW-1:0] CrcInit = 16'hFFFF;
  localparam logic [CrcW-1:0] CrcPoly = 16'hA001;

  // Position of a word within the eight-byte frame.
  typedef enum logic [PosW-1:0] {
    PosAddr  = 3'd0,
    PosFunc  = 3'd1,
    PosRegHi = 3'd2,
    PosRegLo = 3'd3,
    PosValHi = 3'd4,
    PosValLo = 3'd5,
    PosCrcLo = 3'd6,
    PosCrcHi = 3'd7
  } pos_e;

  typedef struct packed {
    logic [ByteW-1:0]    server_addr;
    logic [ByteW-1:0]    function_code;
    logic [RegAddrW-1:0] reg_addr;
    logic [ByteW-1:0]    value_high;
    logic [ByteW-1:0]    value_low;
  } req_t;

  // Reflected CRC-16 update over one byte, least significant bit first.
  function automatic logic [CrcW-1:0] crc_update(input logic [CrcW-1:0] crc_in,
                                                 input logic [ByteW-1:0] data);
    logic [CrcW-1:0] crc;
    crc = crc_in ^ {{(CrcW-ByteW){1'b0}}, data};
    for (int unsigned b = 0; b < ByteW; b++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CrcPoly;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

// File: hdl/mrf_if.sv
`default_nettype none

interface mrf_req_if;
  import mrf_pkg::*;

  logic                valid;
  logic                ready;
  logic [ByteW-1:0]    server_addr;
  logic [ByteW-1:0]    function_code;
  logic [RegAddrW-1:0] reg_addr;
  logic [ByteW-1:0]    value_high;
  logic [ByteW-1:0]    value_low;

  modport source (
    output valid, server_addr, function_code, reg_addr, value_high, value_low,
    input  ready
  );

  modport sink (
    input  valid, server_addr, function_code, reg_addr, value_high, value_low,
    output ready
  );
endinterface

interface mrf_byte_if;
  import mrf_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] tx_byte;
  logic             last_byte;

  modport source (
    output valid, tx_byte, last_byte,
    input  ready
  );

  modport sink (
    input  valid, tx_byte, last_byte,
    output ready
  );
endinterface

`default_nettype wire

// File: hdl/mrf_serializer.sv
`default_nettype none

module mrf_serializer
  import mrf_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  mrf_req_if.sink      req_i,
  mrf_byte_if.source   byte_o
);

  logic            busy_q, busy_d;
  pos_e            pos_q, pos_d;
  logic [CrcW-1:0] crc_q, crc_d;
  req_t            req_q, req_d;
  logic            req_fire;
  logic            byte_fire;
  logic            at_last;
  logic [ByteW-1:0] cur_byte;

  assign at_last   = (pos_q == PosCrcHi);
  assign byte_fire = byte_o.valid && byte_o.ready;
  assign req_i.ready = !busy_q || (at_last && byte_fire);
  assign req_fire  = req_i.valid && req_i.ready;

  always_comb begin
    case (pos_q)
      PosAddr:  cur_byte = req_q.server_addr;
      PosFunc:  cur_byte = req_q.function_code;
      PosRegHi: cur_byte = req_q.reg_addr[RegAddrW-1 -: ByteW];
      PosRegLo: cur_byte = req_q.reg_addr[ByteW-1:0];
      PosValHi: cur_byte = req_q.value_high;
      PosValLo: cur_byte = req_q.value_low;
      PosCrcLo: cur_byte = crc_q[ByteW-1:0];
      PosCrcHi: cur_byte = crc_q[CrcW-1 -: ByteW];
      default:  cur_byte = '0;
    endcase
  end

  assign byte_o.valid     = busy_q;
  assign byte_o.tx_byte   = cur_byte;
  assign byte_o.last_byte = at_last;

  always_comb begin
    busy_d = busy_q;
    pos_d  = pos_q;
    crc_d  = crc_q;
    req_d  = req_q;
    if (byte_fire) begin
      if (at_last) begin
        busy_d = 1'b0;
      end else begin
        pos_d = pos_e'(pos_q + 1'b1);
      end
      if (pos_q != PosCrcLo && pos_q != PosCrcHi) begin
        crc_d = crc_update(crc_q, cur_byte);
      end
    end
    if (req_fire) begin
      busy_d = 1'b1;
      pos_d  = PosAddr;
      crc_d  = CrcInit;
      req_d  = '{server_addr:   req_i.server_addr,
                 function_code: req_i.function_code,
                 reg_addr:      req_i.reg_addr,
                 value_high:    req_i.value_high,
                 value_low:     req_i.value_low};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pos_q  <= PosAddr;
    end else begin
      busy_q <= busy_d;
      pos_q  <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q <= crc_d;
    req_q <= req_d;
  end

`ifndef SYNTHESIS
  a_accept_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && busy_q) |-> (at_last && byte_fire))
    else $error("Request taken while a frame was still in progress.");

  a_accept_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> (busy_q && pos_q == PosAddr && crc_q == CrcInit))
    else $error("Accepted request did not restart the frame.");

  a_position_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (byte_fire && !at_last) |=> (busy_q && pos_q == pos_e'($past(pos_q) + 1'b1)))
    else $error("Frame position did not advance by one word.");
`endif

endmodule

`default_nettype wire

// File: hdl/mrf_out_reg.sv
`default_nettype none

module mrf_out_reg
  import mrf_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  mrf_byte_if.sink    in_i,
  mrf_byte_if.source  out_o
);

  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q;
  logic             last_q;
  logic             load;

  assign in_i.ready = !valid_q || out_o.ready;
  assign load       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (in_i.ready) begin
      valid_d = in_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= in_i.tx_byte;
      last_q <= in_i.last_byte;
    end
  end

  assign out_o.valid     = valid_q;
  assign out_o.tx_byte   = byte_q;
  assign out_o.last_byte = last_q;

`ifndef SYNTHESIS
  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> valid_q)
    else $error("Loaded word not presented at the output.");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !out_o.ready) |-> !in_i.ready)
    else $error("Input accepted while the output word was stalled.");

  a_drain_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && out_o.ready && !in_i.valid) |=> !valid_q)
    else $error("Output word repeated after it was taken.");
`endif

endmodule

`default_nettype wire

// File: hdl/modbus_rtu_request_framer.sv
`default_nettype none

// Builds an eight-byte Modbus RTU request from one request word and sends it one byte
// per cycle while the output is not stalled: server address, function code, register
// address high and low, value high and low, then the CRC-16/MODBUS low byte and high
// byte, with last_byte set on the final byte. The CRC is updated with each body byte as
// it leaves, and a new request is taken in the same cycle its predecessor's last byte
// moves into the output register, so frames can follow back to back. The output
// register lets the framer take the next request while the final byte still waits
// downstream.

module modbus_rtu_request_framer
  import mrf_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  mrf_req_if.sink     req_i,
  mrf_byte_if.source  tx_o
);

  mrf_byte_if ser_byte ();

  mrf_serializer u_ser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .byte_o (ser_byte)
  );

  mrf_out_reg u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (ser_byte),
    .out_o  (tx_o)
  );

endmodule

`default_nettype wire
